### design/disk_block_allocator_macros.svh
// Assertion macros used by the allocator control RTL.
`ifndef DISK_BLOCK_ALLOCATOR_MACROS_SVH
`define DISK_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DBA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("allocator check failed");

// Next-cycle implication, checked out of reset.
`define DBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

### design/dba_pkg.sv
// Shared types and constants of the disk block allocator.
`default_nettype none
package dba_pkg;

    localparam int MAX_BLOCKS = 4096;
    localparam int BLK_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = BLK_W + 1;
    localparam int CFG_W      = 13;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_USER_W = 3;

    localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_BLOCKS);
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4096);

    typedef enum logic {
        FN_ALLOC = 1'b0,
        FN_FREE  = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_SPACE   = 2'd1,
        ST_STACK_FULL = 2'd2
    } t_status;

    // Outcome of one request, decided at accept time.
    typedef struct packed {
        logic [BLK_W-1:0] granted;
        t_status          status;
        logic             pop;
    } t_dec;

endpackage
`default_nettype wire

### design/dba_stack_mem.sv
// Free stack storage: one write port, one registered read port.
`default_nettype none
module dba_stack_mem (
    input  wire                       i_clk,
    input  wire                       i_wr_en,
    input  wire [dba_pkg::BLK_W-1:0]  i_wr_addr,
    input  wire [dba_pkg::BLK_W-1:0]  i_wr_data,
    input  wire                       i_rd_en,
    input  wire [dba_pkg::BLK_W-1:0]  i_rd_addr,
    output logic [dba_pkg::BLK_W-1:0] o_rd_data
);
    import dba_pkg::*;

    logic [BLK_W-1:0] r_mem [MAX_BLOCKS];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Hold read data until the next pop.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

### design/dba_ctrl.sv
// Allocation control: bump counter, stack pointer and block count register.
`default_nettype none
`include "disk_block_allocator_macros.svh"
module dba_ctrl (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_accept,
    input  wire                       i_func,
    input  wire [dba_pkg::BLK_W-1:0]  i_blk,
    input  wire                       i_cfg_we,
    input  wire [dba_pkg::CFG_W-1:0]  i_cfg_data,
    output dba_pkg::t_dec             o_dec,
    output logic                      o_wr_en,
    output logic [dba_pkg::BLK_W-1:0] o_wr_addr,
    output logic [dba_pkg::BLK_W-1:0] o_wr_data,
    output logic                      o_rd_en,
    output logic [dba_pkg::BLK_W-1:0] o_rd_addr
);
    import dba_pkg::*;

    logic [CFG_W-1:0] r_total;
    logic [CNT_W-1:0] r_next_fresh, n_next_fresh;
    logic [CNT_W-1:0] r_stack_count, n_stack_count;
    logic [CNT_W-1:0] lim;
    logic             fresh_ok;
    logic [CNT_W-1:0] pop_idx;

    // Clamp the configured count to the store size.
    assign lim      = (r_total > CFG_W'(MAX_BLOCKS)) ? MAX_CNT : CNT_W'(r_total);
    assign fresh_ok = r_next_fresh < lim;
    assign pop_idx  = r_stack_count - CNT_W'(1);

    always_comb begin
        o_dec         = '{granted: '0, status: ST_OK, pop: 1'b0};
        n_next_fresh  = r_next_fresh;
        n_stack_count = r_stack_count;
        o_wr_en       = 1'b0;
        o_rd_en       = 1'b0;
        o_wr_addr     = r_stack_count[BLK_W-1:0];
        o_wr_data     = i_blk;
        o_rd_addr     = pop_idx[BLK_W-1:0];
        case (t_func'(i_func))
            FN_ALLOC: begin
                if (fresh_ok) begin
                    o_dec.granted = r_next_fresh[BLK_W-1:0];
                    n_next_fresh  = r_next_fresh + CNT_W'(1);
                end else if (r_stack_count != '0) begin
                    o_dec.pop     = 1'b1;
                    o_rd_en       = i_accept;
                    n_stack_count = pop_idx;
                end else begin
                    o_dec.status = ST_NO_SPACE;
                end
            end
            FN_FREE: begin
                if (r_stack_count < MAX_CNT) begin
                    o_wr_en       = i_accept;
                    n_stack_count = r_stack_count + CNT_W'(1);
                end else begin
                    o_dec.status = ST_STACK_FULL;
                end
            end
            default: o_dec.status = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total       <= CFG_RESET;
            r_next_fresh  <= '0;
            r_stack_count <= '0;
        end else begin
            if (i_cfg_we) begin
                r_total <= i_cfg_data;
            end
            if (i_accept) begin
                r_next_fresh  <= n_next_fresh;
                r_stack_count <= n_stack_count;
            end
        end
    end

    `DBA_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_stack_count <= MAX_CNT)
    `DBA_ASSERT_NOW(a_fresh_bound, i_clk, i_rst_n, 1'b1, r_next_fresh <= MAX_CNT)
    `DBA_ASSERT_NOW(a_pop_only_when_spent, i_clk, i_rst_n, i_accept && o_dec.pop, !fresh_ok && r_stack_count != '0)
    `DBA_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, i_accept && o_wr_en, r_stack_count == $past(r_stack_count) + CNT_W'(1))

endmodule
`default_nettype wire

### design/disk_block_allocator.sv
// Block allocator: bump counter with a LIFO free stack in block RAM.
// Channels: requests come in on the s side (tuser = func, 0 allocate,
// 1 free; tdata = block number to free). Results leave on the m side
// (tdata = granted block; tuser = status and from-free-list flag).
// The block count register is written on the cfg channel, always ready;
// write it only while no request is in flight: the block does not enforce this.
// A result passes through the decide stage, which registers the decision
// and the stack RAM read data, and then through the output register.
// Throughput: one request per cycle while the output is not stalled; each
// request makes at most one stack RAM access (one push or one pop) in the decide stage.
// Reset: bump counter and stack count clear, block count returns to 4096;
// stack contents stay as they were and are only read after a push.
// Stall: a held result keeps its value; one more request can still be
// decided behind it, after which s_axis_tready drops until the output drains.
`default_nettype none
module disk_block_allocator (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire [dba_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // [11:0] block_number
    input  wire                            s_axis_tuser,  // [0] func
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    output logic [dba_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // [11:0] granted_block
    output logic [dba_pkg::OUT_USER_W-1:0] m_axis_tuser,  // [1:0] status, [2] from_free_list
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire [dba_pkg::CFG_W-1:0]       i_cfg_data
);
    import dba_pkg::*;

    logic             accept;
    logic             s2_adv;
    t_dec             dec;
    logic             wr_en, rd_en;
    logic [BLK_W-1:0] wr_addr, wr_data, rd_addr, rd_data;
    logic             r_s2_valid;
    t_dec             r_s2_dec;
    logic             r_out_valid;
    logic [BLK_W-1:0] r_out_blk, n_out_blk;
    t_status          r_out_status;
    logic             r_out_pop;

    assign o_cfg_ready   = 1'b1;
    assign s2_adv        = r_s2_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s2_valid || s2_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    dba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_func     (s_axis_tuser),
        .i_blk      (s_axis_tdata[BLK_W-1:0]),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_dec      (dec),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr)
    );

    dba_stack_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Popped blocks are read from RAM as the decision is registered.
    assign n_out_blk = r_s2_dec.pop ? rd_data : r_s2_dec.granted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s2_valid <= 1'b1;
            end else if (s2_adv) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s2_dec <= dec;
        end
        if (s2_adv) begin
            r_out_blk    <= n_out_blk;
            r_out_status <= r_s2_dec.status;
            r_out_pop    <= r_s2_dec.pop;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_out_blk);
    assign m_axis_tuser  = {r_out_pop, r_out_status};

endmodule
`default_nettype wire
